// File: rtl/ptb_pkg.sv
// Package for the PWM tone beep controller: field widths, command codes
// and the packed beat types of the request and response channels.
// No dependencies.
package ptb_pkg;

   localparam int CLK_W   = 28;
   localparam int FREQ_W  = 20;
   localparam int DUR_W   = 16;
   localparam int DIV_W   = 8;
   localparam int WRAP_W  = 16;
   localparam int LEVEL_W = 15;

   localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(125000000);

   // command codes carried in the op field; the fourth code is unused
   localparam logic [1:0] OP_BEEP    = 2'd0;
   localparam logic [1:0] OP_SILENCE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [FREQ_W-1:0] freq_hz;
      logic [DUR_W-1:0]  length_ms;
   } req_type;

   typedef struct packed {
      logic [DIV_W-1:0]   clock_divider;
      logic [WRAP_W-1:0]  wrap_top;
      logic [LEVEL_W-1:0] duty_level;
      logic               sounding;
      logic               freq_error;
   } rsp_type;

endpackage

// File: rtl/ptb_div_serial.sv
// Bit-serial restoring divider: one quotient bit per cycle, WIDTH bits in all.
// Used by the tone controller to form the PWM wrap quotient.
// Depends on nothing outside this file.
module ptb_div_serial #(
   parameter int WIDTH = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   // shift the next dividend bit into the partial remainder and try the divisor
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CNT_W'(WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/pwm_tone_beep_controller_unit.sv
// PWM tone beep controller: interprets beep, silence and tick commands and
// reports the PWM divider, wrap and duty settings. Uses ptb_pkg and
// the bit-serial divider ptb_div_serial.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one command beat:
//   beep, silence or one-millisecond tick. rsp channel (rsp_valid/rsp_stall/
//   rsp_data) returns exactly one beat per command: the settings in effect
//   after it. csr channel (csr_valid/csr_ready/csr_data) writes the source
//   clock frequency; csr_ready is always high, write only while idle.
// Timing:
//   One command at a time. Silence, tick and a rejected beep go straight
//   to S_EMIT, which loads the response once the output is free. A beep
//   walks the divider search one candidate per cycle (1 to DIVIDER_LIMIT),
//   then the 28-bit bit-serial divider if one fits, else uses WRAP_LIMIT.
//   The next command is taken the cycle after the response registers.
// Reset:
//   Clock register returns to 125 MHz, tone muted, divider 1, top 0,
//   error flag clear. A stalled response holds in its output register; a
//   new command may be accepted and computed meanwhile, and waits to emit.
module pwm_tone_beep_controller_unit #(
   parameter int WRAP_LIMIT    = 65535,
   parameter int DIVIDER_LIMIT = 255,
   parameter int DURATION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptb_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptb_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ptb_pkg::CLK_W-1:0] csr_data
);

   import ptb_pkg::*;

   localparam int SPAN_W = $clog2(WRAP_LIMIT + 2);
   localparam int ACC2_W = CLK_W + SPAN_W;
   localparam logic [SPAN_W-1:0] WRAP_SPAN = SPAN_W'(WRAP_LIMIT + 1);
   localparam int DUR_CAP = (DURATION_BITS >= DUR_W) ? (2 ** DUR_W) - 1
                                                     : (2 ** DURATION_BITS) - 1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_DIV    = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CLK_W-1:0]   clk_hz_ff;
   logic [DUR_W-1:0]   remaining_ff, remaining_in;
   logic               pending_ff, pending_in;
   logic [DIV_W-1:0]   divider_ff, divider_in;
   logic [WRAP_W-1:0]  top_ff, top_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               error_ff, error_in;

   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic [DIV_W-1:0]   d_ff, d_in;
   logic [CLK_W-1:0]   acc_ff, acc_in;
   logic [ACC2_W-1:0]  acc2_ff, acc2_in;
   logic [ACC2_W-1:0]  step_ff, step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic               div_start;
   logic               div_done;
   logic [CLK_W-1:0]   div_quo;
   logic               apply;
   logic               rsp_load;
   logic [WRAP_W-1:0]  q_sel;
   logic [DUR_W-1:0]   dur_sat;
   logic [DUR_W-1:0]   rem_dec;

   ptb_div_serial #(
      .WIDTH(CLK_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(clk_hz_ff),
      .divisor (acc_ff),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // saturate the beep length and pick the quotient for the final settings
   assign dur_sat = (dur_ff > DUR_W'(DUR_CAP)) ? DUR_W'(DUR_CAP) : dur_ff;
   assign q_sel   = (state_ff == S_DIV) ? div_quo[WRAP_W-1:0] : WRAP_W'(WRAP_LIMIT);
   assign rem_dec = (remaining_ff != '0) ? remaining_ff - DUR_W'(1) : '0;

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      pending_in   = pending_ff;
      divider_in   = divider_ff;
      top_in       = top_ff;
      level_in     = level_ff;
      error_in     = error_ff;
      freq_in      = freq_ff;
      dur_in       = dur_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      acc2_in      = acc2_ff;
      step_in      = step_ff;
      div_start    = 1'b0;
      apply        = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               freq_in  = req_data.freq_hz;
               dur_in   = req_data.length_ms;
               d_in     = DIV_W'(1);
               acc_in   = CLK_W'(req_data.freq_hz);
               step_in  = ACC2_W'(req_data.freq_hz) * ACC2_W'(WRAP_SPAN);
               acc2_in  = step_in;
               state_in = S_EMIT;
               case (req_data.op)
                  OP_BEEP: begin
                     pending_in   = 1'b0;
                     remaining_in = '0;
                     level_in     = '0;
                     if (req_data.freq_hz == '0 ||
                         clk_hz_ff < CLK_W'(req_data.freq_hz)) begin
                        error_in = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_SILENCE: begin
                     pending_in   = 1'b0;
                     remaining_in = '0;
                     level_in     = '0;
                  end
                  OP_TICK: begin
                     if (pending_ff) begin
                        if (rem_dec == '0) begin
                           pending_in   = 1'b0;
                           remaining_in = '0;
                           level_in     = '0;
                        end else begin
                           remaining_in = rem_dec;
                        end
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // smallest divider whose product with freq and the wrap span tops the clock
            if (ACC2_W'(clk_hz_ff) < acc2_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (d_ff == DIV_W'(DIVIDER_LIMIT)) begin
               apply = 1'b1;
            end else begin
               d_in    = d_ff + DIV_W'(1);
               acc_in  = acc_ff + CLK_W'(freq_ff);
               acc2_in = acc2_ff + step_ff;
            end
         end
         S_DIV: begin
            if (div_done) begin
               apply = 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // load the new tone settings and arm the countdown unless the length is zero
      if (apply) begin
         divider_in = d_ff;
         top_in     = q_sel - WRAP_W'(1);
         level_in   = q_sel[WRAP_W-1:1];
         error_in   = 1'b0;
         state_in   = S_EMIT;
         if (dur_sat == '0) begin
            level_in = '0;
         end else begin
            remaining_in = dur_sat;
            pending_in   = 1'b1;
         end
      end
   end

   // hold the response beat until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // architectural state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clk_hz_ff    <= CLK_RESET;
         remaining_ff <= '0;
         pending_ff   <= 1'b0;
         divider_ff   <= DIV_W'(1);
         top_ff       <= '0;
         level_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         pending_ff   <= pending_in;
         divider_ff   <= divider_in;
         top_ff       <= top_in;
         level_ff     <= level_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            clk_hz_ff <= csr_data;
         end
      end
   end

   // working registers and response payload
   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      dur_ff  <= dur_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      acc2_ff <= acc2_in;
      step_ff <= step_in;
      if (rsp_load) begin
         rsp_data_ff.clock_divider <= divider_ff;
         rsp_data_ff.wrap_top      <= top_ff;
         rsp_data_ff.duty_level    <= level_ff;
         rsp_data_ff.sounding      <= pending_ff;
         rsp_data_ff.freq_error    <= error_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
